### sv/assert_macros.svh
// assertion macros shared by the grid window presence check rtl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define GWPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define GWPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define GWPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GWPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### sv/gwpc_pkg.sv
// shared types, widths and reset values of the grid window presence check
// no dependencies; used by the interfaces and every module
package gwpc_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int WSIZE_W    = 5;
    localparam int MASK_W     = 10;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // default grid geometry
    localparam int DEF_GRID_COLS  = 5;
    localparam int DEF_GRID_ROWS  = 2;
    localparam int DEF_MAX_WINDOW = 16;

    // register reset values
    localparam logic [PIX_W-1:0]   RST_BIN_THR  = 8'd100;
    localparam logic [COORD_W-1:0] RST_ORIGIN_X = 12'd46;
    localparam logic [COORD_W-1:0] RST_ORIGIN_Y = 12'd45;
    localparam logic [COORD_W-1:0] RST_PITCH    = 12'd50;
    localparam logic [WSIZE_W-1:0] RST_WSIZE    = 5'd10;
    localparam logic [PIX_W-1:0]   RST_MEAN_THR = 8'd100;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_THR  = 3'd0,
        CFG_ORIGIN_X = 3'd1,
        CFG_ORIGIN_Y = 3'd2,
        CFG_PITCH    = 3'd3,
        CFG_WSIZE    = 3'd4,
        CFG_MEAN_THR = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]   bin_threshold;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] pitch;
        logic [WSIZE_W-1:0] window_size;
        logic [PIX_W-1:0]   mean_threshold;
    } t_cfg;

    // one pixel request
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } t_pix;

endpackage

### sv/gwpc_pix_if.sv
// pixel request channel of the grid window presence check
// depends on gwpc_pkg
interface gwpc_pix_if import gwpc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;

    modport source (output valid, pixel, col, row, frame_end, input ready);
    modport sink   (input valid, pixel, col, row, frame_end, output ready);

endinterface

### sv/gwpc_res_if.sv
// frame result channel of the grid window presence check
// depends on gwpc_pkg
interface gwpc_res_if import gwpc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] missing_mask;
    logic              complete;

    modport source (output valid, missing_mask, complete, input ready);
    modport sink   (input valid, missing_mask, complete, output ready);

endinterface

### sv/gwpc_grid.sv
// window geometry, per-window bright counters and the missing test
// depends on gwpc_pkg and assert_macros.svh
`include "assert_macros.svh"

module gwpc_grid import gwpc_pkg::*; #(
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_pix              i_item,
    input  logic              i_advance,
    output logic [MASK_W-1:0] o_mask,
    output logic              o_complete
);

    localparam int NWIN     = GRID_COLS * GRID_ROWS;
    localparam int SIZE_W   = $clog2(MAX_WINDOW + 1);
    localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int SPAN_W   = COORD_W + $clog2(GRID_MAX) + 1;
    localparam int SQ_W     = 2 * SIZE_W;
    localparam int LIM_W    = PIX_W + SQ_W;
    localparam int PROD_W   = CNT_W + PIX_W;
    localparam int CMP_W    = (LIM_W > PROD_W) ? LIM_W : PROD_W;
    localparam int WS_CODES = 2 ** WSIZE_W;

    // square of the saturated window size, worked out at elaboration
    function automatic logic [SQ_W-1:0] sq_of(input int v);
        int s;
        s = (v > MAX_WINDOW) ? MAX_WINDOW : v;
        return SQ_W'(s * s);
    endfunction

    logic [SQ_W-1:0]   w_sq_tab [WS_CODES];
    logic [SIZE_W-1:0] n_size;
    logic [LIM_W-1:0]  n_limit;
    logic [LIM_W-1:0]  r_limit;

    logic [SPAN_W-1:0] r_x0 [GRID_COLS];
    logic [SPAN_W-1:0] r_x1 [GRID_COLS];
    logic [SPAN_W-1:0] r_y0 [GRID_ROWS];
    logic [SPAN_W-1:0] r_y1 [GRID_ROWS];

    logic              w_in_x [GRID_COLS];
    logic              w_in_y [GRID_ROWS];
    logic              w_bright;
    logic [NWIN-1:0]   w_missing;
    logic [NWIN-1:0]   w_cnt_nz;
    logic [CNT_W-1:0]  r_cnt [NWIN];

    for (genvar w = 0; w < WS_CODES; w++) begin : g_sq
        localparam logic [SQ_W-1:0] SQ = sq_of(w);
        assign w_sq_tab[w] = SQ;
    end

    // effective size and mean limit follow the registers
    always_comb begin
        n_size = (int'(i_cfg.window_size) > MAX_WINDOW) ? SIZE_W'(MAX_WINDOW)
                                                        : SIZE_W'(i_cfg.window_size);
        n_limit = LIM_W'(i_cfg.mean_threshold) * LIM_W'(w_sq_tab[i_cfg.window_size]);
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
    end

    // column bounds of each window
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        logic [SPAN_W-1:0] n_x0;
        assign n_x0 = SPAN_W'(i_cfg.origin_x) + SPAN_W'(i_cfg.pitch) * SPAN_W'(c);
        always_ff @(posedge i_clk) begin
            r_x0[c] <= n_x0;
            r_x1[c] <= n_x0 + SPAN_W'(n_size);
        end
        assign w_in_x[c] = (SPAN_W'(i_item.col) >= r_x0[c]) &&
                           (SPAN_W'(i_item.col) < r_x1[c]);
    end

    // row bounds of each window
    for (genvar r = 0; r < GRID_ROWS; r++) begin : g_row
        logic [SPAN_W-1:0] n_y0;
        assign n_y0 = SPAN_W'(i_cfg.origin_y) + SPAN_W'(i_cfg.pitch) * SPAN_W'(r);
        always_ff @(posedge i_clk) begin
            r_y0[r] <= n_y0;
            r_y1[r] <= n_y0 + SPAN_W'(n_size);
        end
        assign w_in_y[r] = (SPAN_W'(i_item.row) >= r_y0[r]) &&
                           (SPAN_W'(i_item.row) < r_y1[r]);
    end

    assign w_bright = i_item.pixel > i_cfg.bin_threshold;

    // one saturating counter and mean test per window
    for (genvar r = 0; r < GRID_ROWS; r++) begin : g_lane_r
        for (genvar c = 0; c < GRID_COLS; c++) begin : g_lane_c
            localparam int K = r * GRID_COLS + c;
            logic             w_hit;
            logic [CNT_W-1:0] w_next;
            logic [CMP_W-1:0] w_prod;

            assign w_hit  = w_bright && w_in_x[c] && w_in_y[r] && (r_cnt[K] != CNT_MAX);
            assign w_next = w_hit ? r_cnt[K] + CNT_W'(1) : r_cnt[K];
            // count * 255 as a shift and subtract
            assign w_prod = (CMP_W'(w_next) << PIX_W) - CMP_W'(w_next);
            assign w_missing[K] = w_prod < CMP_W'(r_limit);
            assign w_cnt_nz[K]  = |r_cnt[K];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt[K] <= '0;
                end else if (i_advance) begin
                    r_cnt[K] <= i_item.frame_end ? '0 : w_next;
                end
            end
        end
    end

    // mask keeps the low windows, complete sees them all
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < NWIN) begin : g_used
            assign o_mask[b] = w_missing[b];
        end else begin : g_unused
            assign o_mask[b] = 1'b0;
        end
    end

    assign o_complete = ~|w_missing;

    `GWPC_ASSERT(a_clear_after_frame, i_clk, i_rst_n, (i_advance && i_item.frame_end) |=> (w_cnt_nz == '0), "counters not cleared after frame end")
    `GWPC_ASSERT(a_cnt_monotonic, i_clk, i_rst_n, (i_rst_n && !(i_advance && i_item.frame_end)) |=> (r_cnt[0] >= $past(r_cnt[0])), "window counter decreased inside a frame")

endmodule

### sv/grid_window_presence_check.sv
// top level of the grid window presence check: registers, input and result stages
// depends on gwpc_pkg, gwpc_pix_if, gwpc_res_if, gwpc_grid and assert_macros.svh
// a frame-end request passes the input register and then the result register
// throughput: one pixel request per cycle; stalls only while a result waits
// and the next frame-end request would need the result register
// reset: synchronous, active low; counters zero, registers at reset values
`include "assert_macros.svh"

module grid_window_presence_check import gwpc_pkg::*; #(
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gwpc_pix_if.sink              i_pix,
    gwpc_res_if.source            o_res
);

    localparam int NWIN = GRID_COLS * GRID_ROWS;

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic              r_in_valid;
    t_pix              r_in;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_complete;
    logic              w_out_free;
    logic              w_adv;
    logic              w_accept;
    logic [MASK_W-1:0] w_mask;
    logic              w_complete;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BIN_THR:  n_cfg.bin_threshold  = i_cfg_data[PIX_W-1:0];
                CFG_ORIGIN_X: n_cfg.origin_x       = i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y: n_cfg.origin_y       = i_cfg_data[COORD_W-1:0];
                CFG_PITCH:    n_cfg.pitch          = i_cfg_data[COORD_W-1:0];
                CFG_WSIZE:    n_cfg.window_size    = i_cfg_data[WSIZE_W-1:0];
                CFG_MEAN_THR: n_cfg.mean_threshold = i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_threshold  <= RST_BIN_THR;
            r_cfg.origin_x       <= RST_ORIGIN_X;
            r_cfg.origin_y       <= RST_ORIGIN_Y;
            r_cfg.pitch          <= RST_PITCH;
            r_cfg.window_size    <= RST_WSIZE;
            r_cfg.mean_threshold <= RST_MEAN_THR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // pipeline flow: a pixel leaves the input stage unless its result has no room
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_adv      = r_in_valid && (!r_in.frame_end || w_out_free);
    assign i_pix.ready = !r_in_valid || w_adv;
    assign w_accept   = i_pix.valid && i_pix.ready;

    // input request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.pixel     <= i_pix.pixel;
            r_in.col       <= i_pix.col;
            r_in.row       <= i_pix.row;
            r_in.frame_end <= i_pix.frame_end;
        end
    end

    gwpc_grid #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_grid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (r_in),
        .i_advance  (w_adv),
        .o_mask     (w_mask),
        .o_complete (w_complete)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.frame_end) begin
            r_out_mask     <= w_mask;
            r_out_complete <= w_complete;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.missing_mask = r_out_mask;
    assign o_res.complete     = r_out_complete;

    `GWPC_ASSERT(a_frame_end_gives_result, i_clk, i_rst_n, (w_adv && r_in.frame_end) |=> r_out_valid, "frame end did not load the result register")
    `GWPC_ASSERT(a_result_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_adv && r_in.frame_end), "result appeared without a frame end")
    `GWPC_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_adv && r_in.frame_end && r_out_valid && !o_res.ready, "pending result overwritten")
    `GWPC_ASSERT(a_complete_matches_mask, i_clk, i_rst_n, r_out_valid |-> ((NWIN > MASK_W) || (r_out_complete == (r_out_mask == '0))), "complete flag disagrees with mask")

endmodule

### sim/testbench.sv
// testbench for grid_window_presence_check: directed table, then random frames per setting
// depends on gwpc_pkg, gwpc_pix_if, gwpc_res_if and the grid_window_presence_check rtl
// expected verdicts come from a local window counter model or from hand-written table rows, checked field by field
module testbench
    import gwpc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWIN          = DEF_GRID_COLS * DEF_GRID_ROWS;
    localparam int BRIGHT_LEVEL  = 255;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 45;
    localparam int SAT_ITEMS     = 530;
    localparam int BACKLOG_ITEMS = 40;
    localparam int NUM_SETTINGS  = 12;
    localparam int SAT_SETTING   = NUM_SETTINGS - 1;
    localparam logic [31:0] STALL_PATTERN = 32'b1101_1110_0111_0011_1111_0001_1011_1100;

    // one pixel request with an optional hand-written verdict
    typedef struct {
        t_pix              pix;
        bit                typed;
        logic [MASK_W-1:0] mask;
        logic              cmpl;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              cmpl;
    } t_verdict;

    typedef enum bit { ROW_PIX, ROW_REG } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_req                  req;
    } t_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gwpc_pix_if pix_ch ();
    gwpc_res_if res_ch ();

    // window model state
    t_cfg             model_cfg;
    logic [CNT_W-1:0] win_hits [NWIN];

    t_verdict verdict_q [$];
    t_req     req_q [$];
    t_row     dir_rows [$];
    int       reqs_pending = 0;
    int       errors = 0;
    int       idle_cycles = 0;
    int       hold_seq = 0;
    int       hold_seen, hold_left, rcv_cycle;
    int       burst_left, gap_left;
    t_req     cur_req;

    grid_window_presence_check u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // count one pixel; on a frame end build the verdict and clear the counters
    function automatic bit tally_pixel(input t_pix p, output t_verdict v);
        logic [4:0]  sz;
        logic [15:0] x0, y0;
        logic [31:0] limit;
        bit          any_missing;
        int          k;
        sz = (model_cfg.window_size > 5'(DEF_MAX_WINDOW)) ? 5'(DEF_MAX_WINDOW)
                                                           : model_cfg.window_size;
        v = '0;
        if (p.pixel > model_cfg.bin_threshold) begin
            for (int r = 0; r < DEF_GRID_ROWS; r++) begin
                y0 = 16'(model_cfg.origin_y) + 16'(r) * 16'(model_cfg.pitch);
                for (int c = 0; c < DEF_GRID_COLS; c++) begin
                    x0 = 16'(model_cfg.origin_x) + 16'(c) * 16'(model_cfg.pitch);
                    k  = r * DEF_GRID_COLS + c;
                    if (16'(p.row) >= y0 && 16'(p.row) < y0 + 16'(sz) &&
                        16'(p.col) >= x0 && 16'(p.col) < x0 + 16'(sz) &&
                        win_hits[k] != CNT_MAX) begin
                        win_hits[k]++;
                    end
                end
            end
        end
        if (!p.frame_end)
            return 1'b0;
        // mean test in integers: hits*255 against threshold*area
        limit = 32'(model_cfg.mean_threshold) * 32'(sz) * 32'(sz);
        any_missing = 1'b0;
        for (int w = 0; w < NWIN; w++) begin
            if (32'(win_hits[w]) * 32'(BRIGHT_LEVEL) < limit) begin
                any_missing = 1'b1;
                if (w < MASK_W)
                    v.mask[w] = 1'b1;
            end
            win_hits[w] = '0;
        end
        v.cmpl = !any_missing;
        return 1'b1;
    endfunction

    task automatic report(input string what, input int want_v, input int got_v);
        if (errors < 40)
            $display("%0t ns: %s expected %0h actual %0h", $time, what, want_v, got_v);
        errors++;
    endtask

    // pixel sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            pix_ch.valid     <= 1'b0;
            pix_ch.pixel     <= '0;
            pix_ch.col       <= '0;
            pix_ch.row       <= '0;
            pix_ch.frame_end <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (tally_pixel(cur_req.pix, v)) begin
                    if (cur_req.typed)
                        verdict_q.push_back(t_verdict'{cur_req.mask, cur_req.cmpl});
                    else
                        verdict_q.push_back(v);
                end
                reqs_pending--;
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    pix_ch.valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    pix_ch.valid     <= 1'b1;
                    pix_ch.pixel     <= cur_req.pix.pixel;
                    pix_ch.col       <= cur_req.pix.col;
                    pix_ch.row       <= cur_req.pix.row;
                    pix_ch.frame_end <= cur_req.pix.frame_end;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: checks each verdict, stalls on its own pattern
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
            rcv_cycle = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    if (errors < 40)
                        $display("%0t ns: result with nothing expected, mask %0h complete %0b",
                                 $time, res_ch.missing_mask, res_ch.complete);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (res_ch.missing_mask !== want.mask)
                        report("missing_mask", want.mask, res_ch.missing_mask);
                    if (res_ch.complete !== want.cmpl)
                        report("complete", want.cmpl, res_ch.complete);
                end
            end
            rcv_cycle++;
            // long hold-off so the block backs up and stalls its input
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case ((rcv_cycle / 128) % 3)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= STALL_PATTERN[rcv_cycle % 32];
                    default: res_ch.ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_ch.valid && pix_ch.ready) ||
            (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("grid_window_presence_check verification failed");
            $finish;
        end
    end

    task automatic post(input t_req rq);
        req_q.push_back(rq);
        reqs_pending++;
    endtask

    // wait until every request is taken and every verdict has arrived
    task automatic settle();
        while (reqs_pending != 0 || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_BIN_THR:  model_cfg.bin_threshold  = val[PIX_W-1:0];
            CFG_ORIGIN_X: model_cfg.origin_x       = val[COORD_W-1:0];
            CFG_ORIGIN_Y: model_cfg.origin_y       = val[COORD_W-1:0];
            CFG_PITCH:    model_cfg.pitch          = val[COORD_W-1:0];
            CFG_WSIZE:    model_cfg.window_size    = val[WSIZE_W-1:0];
            CFG_MEAN_THR: model_cfg.mean_threshold = val[PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_BIN_THR,  CFG_DATA_W'(c.bin_threshold));
        write_reg(CFG_ORIGIN_X, CFG_DATA_W'(c.origin_x));
        write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(c.origin_y));
        write_reg(CFG_PITCH,    CFG_DATA_W'(c.pitch));
        write_reg(CFG_WSIZE,    CFG_DATA_W'(c.window_size));
        write_reg(CFG_MEAN_THR, CFG_DATA_W'(c.mean_threshold));
    endtask

    task automatic add_pix(input int px, input int cl, input int rw, input bit fe,
                           input bit typed = 1'b0, input int mask = 0, input bit cmpl = 1'b0);
        t_row row;
        row.kind          = ROW_PIX;
        row.reg_idx       = CFG_BIN_THR;
        row.reg_val       = '0;
        row.req.pix       = '{PIX_W'(px), COORD_W'(cl), COORD_W'(rw), fe};
        row.req.typed     = typed;
        row.req.mask      = MASK_W'(mask);
        row.req.cmpl      = cmpl;
        dir_rows.push_back(row);
    endtask

    task automatic add_reg(input t_cfg_idx idx, input int val);
        t_row row;
        row.kind      = ROW_REG;
        row.reg_idx   = idx;
        row.reg_val   = CFG_DATA_W'(val);
        row.req.pix   = '0;
        row.req.typed = 1'b0;
        row.req.mask  = '0;
        row.req.cmpl  = 1'b0;
        dir_rows.push_back(row);
    endtask

    // one random frame: mostly pixels around the windows, some noise,
    // now and then a stray frame end in the middle
    task automatic queue_frame(input int len);
        t_req rq;
        int   sz, c, r;
        sz = (model_cfg.window_size > 5'(DEF_MAX_WINDOW)) ? DEF_MAX_WINDOW
                                                           : int'(model_cfg.window_size);
        if (sz == 0)
            sz = 1;
        rq.typed = 1'b0;
        rq.mask  = '0;
        rq.cmpl  = 1'b0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                rq.pix.pixel = PIX_W'($urandom);
                rq.pix.col   = COORD_W'($urandom);
                rq.pix.row   = COORD_W'($urandom);
            end else begin
                c = $urandom_range(0, DEF_GRID_COLS - 1);
                r = $urandom_range(0, DEF_GRID_ROWS - 1);
                rq.pix.col = COORD_W'(int'(model_cfg.origin_x) + c * int'(model_cfg.pitch)
                                      + int'($urandom_range(0, sz + 1)) - 1);
                rq.pix.row = COORD_W'(int'(model_cfg.origin_y) + r * int'(model_cfg.pitch)
                                      + int'($urandom_range(0, sz + 1)) - 1);
                if ($urandom_range(0, 9) < 7)
                    rq.pix.pixel = PIX_W'($urandom_range(255, int'(model_cfg.bin_threshold)));
                else
                    rq.pix.pixel = PIX_W'($urandom_range(int'(model_cfg.bin_threshold), 0));
            end
            rq.pix.frame_end = (i == len - 1) || ($urandom_range(0, 99) == 0);
            post(rq);
        end
    endtask

    initial begin
        t_cfg plan [NUM_SETTINGS];
        t_req rq;
        int   made, len;

        // settings: bin, origin x, origin y, pitch, size, mean
        plan = '{
            '{8'd60,  12'd0,    12'd0,    12'd4,    5'd3,  8'd128},
            '{8'd200, 12'd10,   12'd20,   12'd2,    5'd5,  8'd60},   // overlapping windows
            '{8'd128, 12'd100,  12'd200,  12'd0,    5'd4,  8'd200},  // all windows at origin
            '{8'd255, 12'd5,    12'd5,    12'd6,    5'd4,  8'd1},    // nothing bright
            '{8'd0,   12'd30,   12'd40,   12'd7,    5'd0,  8'd255},  // empty windows
            '{8'd100, 12'd0,    12'd0,    12'd16,   5'd31, 8'd255},  // size saturates
            '{8'd90,  12'd4090, 12'd4085, 12'd4095, 5'd16, 8'd0},    // grid past the edge
            '{8'd90,  12'd4090, 12'd4090, 12'd1,    5'd16, 8'd40},
            '{8'd0,   12'd0,    12'd0,    12'd4095, 5'd1,  8'd255},
            '{8'd50,  12'd8,    12'd8,    12'd3,    5'd2,  8'd255},
            '{RST_BIN_THR, RST_ORIGIN_X, RST_ORIGIN_Y, RST_PITCH, RST_WSIZE, RST_MEAN_THR},
            '{8'd0,   12'd20,   12'd20,   12'd0,    5'd16, 8'd255}   // counter saturation
        };

        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_BIN_THR;
        i_cfg_data       <= '0;

        model_cfg = '{RST_BIN_THR, RST_ORIGIN_X, RST_ORIGIN_Y, RST_PITCH, RST_WSIZE, RST_MEAN_THR};
        foreach (win_hits[k])
            win_hits[k] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset settings: a window needs 40 hits to be present
        add_pix(0,   0,    0,    1'b1, 1'b1, 'h3ff, 1'b0);
        add_pix(255, 4095, 4095, 1'b0);
        add_pix(101, 46,   45,   1'b0);
        add_pix(100, 46,   45,   1'b0);
        add_pix(255, 55,   54,   1'b0);
        add_pix(255, 56,   45,   1'b0);
        add_pix(255, 96,   95,   1'b0);
        add_pix(255, 246,  95,   1'b0);
        add_pix(0,   0,    0,    1'b1, 1'b1, 'h3ff, 1'b0);
        // one-pixel windows, one hit makes a window present
        add_reg(CFG_BIN_THR,  0);
        add_reg(CFG_ORIGIN_X, 0);
        add_reg(CFG_ORIGIN_Y, 0);
        add_reg(CFG_PITCH,    1);
        add_reg(CFG_WSIZE,    1);
        add_reg(CFG_MEAN_THR, 255);
        // frame end pixel counts before the verdict
        add_pix(255, 0, 0, 1'b1, 1'b1, 'h3fe, 1'b0);
        add_pix(0,   0, 0, 1'b1, 1'b1, 'h3ff, 1'b0);
        for (int r = 0; r < DEF_GRID_ROWS; r++)
            for (int c = 0; c < DEF_GRID_COLS; c++)
                add_pix(1, c, r, (r == DEF_GRID_ROWS - 1) && (c == DEF_GRID_COLS - 1),
                        1'b1, 0, 1'b1);
        // zero mean threshold never marks a window
        add_reg(CFG_MEAN_THR, 0);
        add_pix(7, 4095, 0, 1'b1, 1'b1, 0, 1'b1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                post(dir_rows[i].req);
            end
        end

        // random frames under each setting
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle();
            load_settings(plan[s]);
            if (s == 0) begin
                // receiver holds off while short frames pile up
                hold_seq++;
                queue_frame(1);
                for (int i = 1; i < BACKLOG_ITEMS; i++)
                    queue_frame($urandom_range(1, 3));
            end
            if (s == SAT_SETTING) begin
                // far more hits than a counter holds, all windows overlap
                rq.typed = 1'b0;
                rq.mask  = '0;
                rq.cmpl  = 1'b0;
                for (int i = 0; i < SAT_ITEMS; i++) begin
                    rq.pix = '{8'd255, COORD_W'(20 + $urandom_range(0, 15)),
                               COORD_W'(20 + $urandom_range(0, 15)), i == SAT_ITEMS - 1};
                    post(rq);
                end
            end
            made = 0;
            while (made < PHASE_ITEMS) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                queue_frame(len);
                made += len;
            end
        end

        settle();
        if (errors == 0)
            $display("grid_window_presence_check verification clean");
        else
            $display("grid_window_presence_check verification failed");
        $finish;
    end

endmodule

### grid_window_presence_check.f
+incdir+sv
sv/gwpc_pkg.sv
sv/gwpc_pix_if.sv
sv/gwpc_res_if.sv
sv/gwpc_grid.sv
sv/grid_window_presence_check.sv
sim/testbench.sv
